FILE: rtl/pfe_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and helpers for the format engine.
// No dependencies; imported by every module of the block.
package pfe_pkg;

    localparam int WIDTH_W = 6;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PCT     = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_MOD_F   = 8'h46;
    localparam logic [7:0] CH_MOD_N   = 8'h4E;
    localparam logic [7:0] CH_MOD_L   = 8'h6C;
    localparam logic [7:0] CH_MOD_H   = 8'h68;
    localparam logic [7:0] CH_CONV_D  = 8'h64;
    localparam logic [7:0] CH_CONV_I  = 8'h69;
    localparam logic [7:0] CH_CONV_U  = 8'h75;
    localparam logic [7:0] CH_CONV_O  = 8'h6F;
    localparam logic [7:0] CH_CONV_LX = 8'h78;
    localparam logic [7:0] CH_CONV_UX = 8'h58;
    localparam logic [7:0] CH_CONV_P  = 8'h70;
    localparam logic [7:0] CH_CONV_N  = 8'h6E;
    localparam logic [7:0] CH_CONV_C  = 8'h63;

    // Reciprocal of ten: floor(v * RECIP10 / 2^RECIP_SHIFT) == v / 10 for all 32-bit v.
    localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    typedef enum logic [1:0] {
        RADIX_8,
        RADIX_10,
        RADIX_16
    } radix_t;

    typedef struct packed {
        logic               is_num;
        logic               upper;
        logic               left;
        logic               pad_zero;
        logic               neg;
        logic [WIDTH_W-1:0] width;
        logic [7:0]         ch;
    } emit_cmd_t;

    function automatic logic [7:0] digit_ascii(input logic [3:0] d, input logic upper);
        logic [7:0] res;
        if (d < 4'd10) begin
            res = CH_ZERO + {4'd0, d};
        end
        else begin
            res = (upper ? CH_UPPER_A : CH_LOWER_A) + {4'd0, d} - 8'd10;
        end
        return res;
    endfunction

endpackage

FILE: rtl/pfe_digit_unit.sv
`timescale 1ns / 1ps
// Iterative digit extractor: one shared reciprocal multiplier peels one digit per step.
// Depends on pfe_pkg; digits are kept least significant first in a small buffer.
module pfe_digit_unit #(
    parameter int DIGIT_BUFFER = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [31:0]                         value,
    input  pfe_pkg::radix_t                     radix,
    output logic                                done,
    output logic [$clog2(DIGIT_BUFFER)-1:0]     nd,
    input  logic [$clog2(DIGIT_BUFFER-1)-1:0]   rd_idx,
    output logic [3:0]                          rd_digit
);
    import pfe_pkg::*;

    localparam int ND_W  = $clog2(DIGIT_BUFFER);
    localparam int DEPTH = DIGIT_BUFFER - 1;
    localparam int IDX_W = $clog2(DEPTH);

    typedef enum logic [1:0] {
        D_IDLE,
        D_MUL,
        D_DIG
    } dstate_t;

    dstate_t           state_reg;
    logic [31:0]       v_reg;
    logic [63:0]       prod_reg;
    radix_t            radix_reg;
    logic [ND_W-1:0]   nd_reg;
    logic              done_reg;
    logic [3:0]        digit_mem [DEPTH];

    logic [31:0]       q;
    logic [31:0]       q10;
    logic [3:0]        d;
    logic              room;

    always_comb
    begin
        q10 = '0;
        unique case (radix_reg)
            RADIX_8:
            begin
                q = {3'd0, v_reg[31:3]};
                d = {1'b0, v_reg[2:0]};
            end
            RADIX_10:
            begin
                q   = 32'(prod_reg[63:RECIP_SHIFT]);
                q10 = (q << 3) + (q << 1);
                d   = v_reg[3:0] - q10[3:0];
            end
            default:
            begin
                q = {4'd0, v_reg[31:4]};
                d = v_reg[3:0];
            end
        endcase
    end

    assign room = nd_reg < ND_W'(DEPTH);

    always_ff @(posedge clk)
    begin
        if (state_reg == D_DIG && room) begin
            digit_mem[nd_reg[IDX_W-1:0]] <= d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= D_IDLE;
            v_reg     <= '0;
            prod_reg  <= '0;
            radix_reg <= RADIX_10;
            nd_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else begin
            done_reg <= (state_reg == D_DIG) && (q == 32'd0);
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start) begin
                        v_reg     <= value;
                        radix_reg <= radix;
                        nd_reg    <= '0;
                        state_reg <= D_MUL;
                    end
                end
                D_MUL:
                begin
                    prod_reg  <= {32'd0, v_reg} * {32'd0, RECIP10};
                    state_reg <= D_DIG;
                end
                D_DIG:
                begin
                    if (room) begin
                        nd_reg <= nd_reg + 1'b1;
                    end
                    v_reg <= q;
                    if (q == 32'd0) begin
                        state_reg <= D_IDLE;
                    end
                    else begin
                        state_reg <= D_MUL;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign nd       = nd_reg;
    assign rd_digit = digit_mem[rd_idx];

endmodule

FILE: rtl/pfe_emitter.sv
`timescale 1ns / 1ps
// Emits sign, padding, body, trailing spaces: one character per cycle unless stalled.
// Depends on pfe_pkg and reads digits from pfe_digit_unit; owns the output register.
module pfe_emitter #(
    parameter int DIGIT_BUFFER = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  pfe_pkg::emit_cmd_t                  cmd,
    input  logic [$clog2(DIGIT_BUFFER)-1:0]     nd,
    output logic [$clog2(DIGIT_BUFFER-1)-1:0]   rd_idx,
    input  logic [3:0]                          rd_digit,
    output logic                                busy,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [7:0]                          out_char,
    output logic                                last
);
    import pfe_pkg::*;

    localparam int ND_W  = $clog2(DIGIT_BUFFER);
    localparam int IDX_W = $clog2(DIGIT_BUFFER - 1);

    emit_cmd_t          cmd_reg;
    logic               sign1_reg;
    logic               sign2_reg;
    logic [6:0]         pre_reg;
    logic [ND_W-1:0]    body_reg;
    logic [6:0]         post_reg;
    logic [6:0]         rem_reg;
    logic               out_valid_reg;
    logic [7:0]         out_char_reg;
    logic               last_reg;

    logic [6:0]         actual;
    logic [6:0]         wide;
    logic [6:0]         gap;
    logic [ND_W-1:0]    body_ld;
    logic               sign1_ld;
    logic               sign2_ld;
    logic [6:0]         pre_ld;
    logic [6:0]         post_ld;
    logic [6:0]         total;
    logic [ND_W-1:0]    body_m1;
    logic               advance;
    logic [7:0]         next_char;

    always_comb
    begin
        actual   = cmd.is_num ? (7'(nd) + 7'(cmd.neg)) : 7'd1;
        wide     = 7'(cmd.width);
        gap      = (wide > actual) ? (wide - actual) : 7'd0;
        body_ld  = cmd.is_num ? nd : ND_W'(cmd.ch != CH_NUL);
        sign1_ld = cmd.neg & cmd.pad_zero;
        sign2_ld = cmd.neg & ~cmd.pad_zero;
        pre_ld   = cmd.left ? 7'd0 : gap;
        post_ld  = cmd.left ? gap : 7'd0;
        total    = 7'(sign1_ld) + pre_ld + 7'(sign2_ld) + 7'(body_ld) + post_ld;
    end

    assign body_m1 = body_reg - 1'b1;
    assign rd_idx  = body_m1[IDX_W-1:0];
    assign advance = (rem_reg != 7'd0) && (!out_valid_reg || out_ready);

    always_comb
    begin
        priority if (sign1_reg) begin
            next_char = CH_MINUS;
        end
        else if (pre_reg != 7'd0) begin
            next_char = cmd_reg.pad_zero ? CH_ZERO : CH_SPACE;
        end
        else if (sign2_reg) begin
            next_char = CH_MINUS;
        end
        else if (body_reg != '0) begin
            next_char = cmd_reg.is_num ? digit_ascii(rd_digit, cmd_reg.upper) : cmd_reg.ch;
        end
        else begin
            next_char = CH_SPACE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cmd_reg       <= '0;
            sign1_reg     <= 1'b0;
            sign2_reg     <= 1'b0;
            pre_reg       <= '0;
            body_reg      <= '0;
            post_reg      <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            last_reg      <= 1'b0;
        end
        else begin
            if (!start && advance) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (start) begin
                cmd_reg   <= cmd;
                sign1_reg <= sign1_ld;
                sign2_reg <= sign2_ld;
                pre_reg   <= pre_ld;
                body_reg  <= body_ld;
                post_reg  <= post_ld;
                rem_reg   <= total;
            end
            else if (advance) begin
                out_char_reg  <= next_char;
                last_reg      <= (rem_reg == 7'd1);
                rem_reg       <= rem_reg - 7'd1;
                priority if (sign1_reg) begin
                    sign1_reg <= 1'b0;
                end
                else if (pre_reg != 7'd0) begin
                    pre_reg <= pre_reg - 7'd1;
                end
                else if (sign2_reg) begin
                    sign2_reg <= 1'b0;
                end
                else if (body_reg != '0) begin
                    body_reg <= body_m1;
                end
                else begin
                    post_reg <= post_reg - 7'd1;
                end
            end
        end
    end

    assign busy      = (rem_reg != 7'd0);
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

endmodule

FILE: rtl/printf_format_engine_core.sv
`timescale 1ns / 1ps
// Top level of the format engine: format-string parser and conversion sequencer.
// Depends on pfe_pkg, pfe_digit_unit and pfe_emitter.
//
// Usage: each input transaction carries one format character (fmt_char) and the
// argument word (arg_value) that a numeric or %c conversion consumes. Each output
// transaction carries one emitted character; last marks the final character that
// belongs to one input. An input that emits nothing produces no output transaction.
// An echoed character is loaded into the emitter on acceptance and then registered
// in the output register. A numeric conversion first extracts its digits in the
// shared reciprocal multiplier (up to eleven digits for octal), then emits its
// characters, up to 63 of them.
// in_ready is high only while no conversion is extracting digits or emitting; the
// final character may still sit in the output register when the next input is taken.
// When the receiver holds out_ready low the output register holds its character
// and the sequencer waits; no character is dropped.
// Reset clears the parser to its idle phase and empties the output register.
module printf_format_engine_core #(
    parameter int MAX_WIDTH    = 63,
    parameter int DIGIT_BUFFER = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  fmt_char,
    input  logic [31:0] arg_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_char,
    output logic        last
);
    import pfe_pkg::*;

    localparam int ND_W  = $clog2(DIGIT_BUFFER);
    localparam int IDX_W = $clog2(DIGIT_BUFFER - 1);

    typedef enum logic [2:0] {
        P_IDLE  = 3'd0,
        P_FLAGS = 3'd1,
        P_WIDTH = 3'd2,
        P_MOD   = 3'd3
    } phase_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } cstate_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_LIT,
        ACT_NUM,
        ACT_CHAR
    } act_t;

    typedef struct packed {
        logic is_short;
        logic is_long;
        logic zero;
        logic left;
    } spec_flags_t;

    cstate_t            state_reg;
    phase_t             phase_reg;
    phase_t             phase_next;
    spec_flags_t        flags_reg;
    spec_flags_t        flags_next;
    logic [WIDTH_W-1:0] width_reg;
    logic [WIDTH_W-1:0] width_next;
    emit_cmd_t          cmd_reg;
    emit_cmd_t          cmd_comb;
    act_t               act;

    logic               accept;
    logic               handled;
    logic               is_digit;
    logic [9:0]         nw;
    logic               conv_num;
    logic               conv_char;
    logic               sgn;
    logic               upper;
    radix_t             radix;
    logic [31:0]        v_sel;
    logic               neg;
    logic [31:0]        mag;

    logic               dig_start;
    logic               dig_done;
    logic [ND_W-1:0]    nd;
    logic [IDX_W-1:0]   rd_idx;
    logic [3:0]         rd_digit;
    logic               emit_start;
    emit_cmd_t          emit_cmd;
    logic               emit_busy;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign is_digit = (fmt_char >= CH_ZERO) && (fmt_char <= CH_NINE);
    assign nw       = ({4'd0, width_reg} << 3) + ({4'd0, width_reg} << 1)
                      + {6'd0, fmt_char[3:0]};

    always_comb
    begin
        conv_num  = 1'b0;
        conv_char = 1'b0;
        sgn       = 1'b0;
        upper     = 1'b0;
        radix     = RADIX_10;
        unique case (fmt_char)
            CH_CONV_UX:
            begin
                conv_num = 1'b1;
                upper    = 1'b1;
                radix    = RADIX_16;
            end
            CH_CONV_LX, CH_CONV_P, CH_CONV_N:
            begin
                conv_num = 1'b1;
                radix    = RADIX_16;
            end
            CH_CONV_D, CH_CONV_I:
            begin
                conv_num = 1'b1;
                sgn      = 1'b1;
            end
            CH_CONV_U:
            begin
                conv_num = 1'b1;
            end
            CH_CONV_O:
            begin
                conv_num = 1'b1;
                radix    = RADIX_8;
            end
            CH_CONV_C:
            begin
                conv_char = 1'b1;
            end
            default:
            begin
                conv_num = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (!flags_reg.is_long && flags_reg.is_short) begin
            v_sel = sgn ? {{16{arg_value[15]}}, arg_value[15:0]} : {16'd0, arg_value[15:0]};
        end
        else begin
            v_sel = arg_value;
        end
        neg = sgn & v_sel[31];
        mag = neg ? (32'd0 - v_sel) : v_sel;
    end

    always_comb
    begin
        phase_next = phase_reg;
        flags_next = flags_reg;
        width_next = width_reg;
        act        = ACT_NONE;
        handled    = 1'b0;
        if (fmt_char == CH_NUL) begin
            phase_next = P_IDLE;
            flags_next = '0;
            width_next = '0;
        end
        else if (phase_reg != P_FLAGS && phase_reg != P_WIDTH && phase_reg != P_MOD) begin
            if (fmt_char == CH_PCT) begin
                phase_next = P_FLAGS;
            end
            else begin
                phase_next = P_IDLE;
                act        = ACT_LIT;
            end
        end
        else begin
            if (phase_reg == P_FLAGS) begin
                priority if (fmt_char == CH_PCT) begin
                    act        = ACT_LIT;
                    phase_next = P_IDLE;
                    flags_next = '0;
                    width_next = '0;
                    handled    = 1'b1;
                end
                else if (fmt_char == CH_MINUS) begin
                    if (flags_reg.left) begin
                        phase_next = P_IDLE;
                        flags_next = '0;
                        width_next = '0;
                    end
                    else begin
                        flags_next.left = 1'b1;
                    end
                    handled = 1'b1;
                end
                else if (fmt_char == CH_ZERO) begin
                    flags_next.zero = 1'b1;
                    phase_next      = P_WIDTH;
                    handled         = 1'b1;
                end
                else begin
                    phase_next = P_WIDTH;
                end
            end
            if (!handled && (phase_reg == P_FLAGS || phase_reg == P_WIDTH)) begin
                if (is_digit) begin
                    width_next = (nw > 10'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : nw[WIDTH_W-1:0];
                    handled    = 1'b1;
                end
                else begin
                    phase_next = P_MOD;
                end
            end
            if (!handled) begin
                priority if (fmt_char == CH_MOD_F || fmt_char == CH_MOD_N) begin
                    phase_next = P_MOD;
                end
                else if (fmt_char == CH_MOD_L) begin
                    phase_next         = P_MOD;
                    flags_next.is_long = 1'b1;
                end
                else if (fmt_char == CH_MOD_H) begin
                    phase_next          = P_MOD;
                    flags_next.is_short = 1'b1;
                end
                else begin
                    phase_next = P_IDLE;
                    flags_next = '0;
                    width_next = '0;
                    if (conv_num) begin
                        act = ACT_NUM;
                    end
                    else if (conv_char) begin
                        act = ACT_CHAR;
                    end
                end
            end
        end
    end

    always_comb
    begin
        cmd_comb = '0;
        unique case (act)
            ACT_NUM:
            begin
                cmd_comb.is_num   = 1'b1;
                cmd_comb.upper    = upper;
                cmd_comb.left     = flags_reg.left;
                cmd_comb.pad_zero = flags_reg.zero;
                cmd_comb.neg      = neg;
                cmd_comb.width    = width_reg;
            end
            ACT_CHAR:
            begin
                cmd_comb.left  = flags_reg.left;
                cmd_comb.width = width_reg;
                cmd_comb.ch    = arg_value[7:0];
            end
            ACT_LIT:
            begin
                cmd_comb.ch = fmt_char;
            end
            default:
            begin
                cmd_comb = '0;
            end
        endcase
    end

    assign dig_start  = accept && (act == ACT_NUM);
    assign emit_start = (accept && (act == ACT_LIT || act == ACT_CHAR))
                        || (state_reg == S_CONV && dig_done);
    assign emit_cmd   = (state_reg == S_CONV) ? cmd_reg : cmd_comb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            phase_reg <= P_IDLE;
            flags_reg <= '0;
            width_reg <= '0;
            cmd_reg   <= '0;
        end
        else begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept) begin
                        phase_reg <= phase_next;
                        flags_reg <= flags_next;
                        width_reg <= width_next;
                        cmd_reg   <= cmd_comb;
                        if (act == ACT_NUM) begin
                            state_reg <= S_CONV;
                        end
                        else if (act == ACT_LIT || act == ACT_CHAR) begin
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_CONV:
                begin
                    if (dig_done) begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (!emit_busy) begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    pfe_digit_unit #(
        .DIGIT_BUFFER (DIGIT_BUFFER)
    ) u_digit_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dig_start),
        .value    (mag),
        .radix    (radix),
        .done     (dig_done),
        .nd       (nd),
        .rd_idx   (rd_idx),
        .rd_digit (rd_digit)
    );

    pfe_emitter #(
        .DIGIT_BUFFER (DIGIT_BUFFER)
    ) u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (emit_start),
        .cmd       (emit_cmd),
        .nd        (nd),
        .rd_idx    (rd_idx),
        .rd_digit  (rd_digit),
        .busy      (emit_busy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last      (last)
    );

endmodule

FILE: verif/printf_format_engine_checker.sv
`timescale 1ns / 1ps
// Scoreboard for printf_format_engine_core: keeps its own copy of the format parser,
// predicts every emitted character and its last flag, and compares in order.
// Depends on pfe_pkg for the character codes and the radix type.
module printf_format_engine_checker #(
    parameter int MAX_WIDTH = 63
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  fmt_char,
    input  logic [31:0] arg_value,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  out_char,
    input  logic        last,
    output int          fail_count,
    output int          pending_results
);
    import pfe_pkg::*;

    localparam int RESULT_CAP = 63;
    localparam int F_LEFT     = 0;
    localparam int F_ZERO     = 1;
    localparam int F_LONG     = 2;
    localparam int F_SHORT    = 3;
    localparam int F_FAR      = 4;

    typedef enum logic [2:0] {
        SCAN_TEXT,
        SCAN_FLAGS,
        SCAN_WIDTH,
        SCAN_MODS
    } scan_phase_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } expected_char_t;

    scan_phase_t        scan;
    logic [7:0]         spec_fl;
    logic [WIDTH_W-1:0] field_w;
    logic [7:0]         emit_buf[$];
    expected_char_t     expected_text[$];

    task automatic reset_spec();
        scan    = SCAN_TEXT;
        spec_fl = 8'd0;
        field_w = '0;
    endtask

    task automatic emit_char(input logic [7:0] ch);
        if (emit_buf.size() < RESULT_CAP)
        begin
            emit_buf.push_back(ch);
        end
    endtask

    task automatic emit_spaces(input int count);
        repeat (count) emit_char(CH_SPACE);
    endtask

    task automatic render_conversion(input logic [7:0] conv, input logic [31:0] arg,
                                     input logic [7:0] flags, input int w);
        logic        is_signed;
        logic        upper;
        logic        negative;
        radix_t      rdx;
        int unsigned base;
        logic [31:0] mag;
        logic [3:0]  d;
        logic [7:0]  glyph;
        logic [7:0]  digits[$];
        int          actual;
        int          rest;
        is_signed = 1'b0;
        upper     = 1'b0;
        rdx       = RADIX_10;
        case (conv)
            CH_CONV_UX:
            begin
                upper = 1'b1;
                rdx   = RADIX_16;
            end
            CH_CONV_LX, CH_CONV_P, CH_CONV_N: rdx = RADIX_16;
            CH_CONV_D, CH_CONV_I:             is_signed = 1'b1;
            CH_CONV_U:                        rdx = RADIX_10;
            CH_CONV_O:                        rdx = RADIX_8;
            CH_CONV_C:
            begin
                rest = (w < 1) ? 0 : w - 1;
                if (!flags[F_LEFT])
                begin
                    emit_spaces(rest);
                    rest = 0;
                end
                if (arg[7:0] != CH_NUL)
                begin
                    emit_char(arg[7:0]);
                end
                emit_spaces(rest);
                return;
            end
            default: return;
        endcase

        base = (rdx == RADIX_8) ? 8 : ((rdx == RADIX_10) ? 10 : 16);
        if (flags[F_LONG] || !flags[F_SHORT])
        begin
            mag = arg;
        end
        else if (is_signed)
        begin
            mag = {{16{arg[15]}}, arg[15:0]};
        end
        else
        begin
            mag = {16'd0, arg[15:0]};
        end
        negative = is_signed && mag[31];
        if (negative)
        begin
            mag = 32'd0 - mag;
        end

        do
        begin
            d = 4'(mag % base);
            if (d < 4'd10)
            begin
                glyph = CH_ZERO + 8'(d);
            end
            else
            begin
                glyph = (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(d) - 8'd10;
            end
            digits.push_front(glyph);
            mag = mag / base;
        end
        while (mag != 32'd0);

        actual = digits.size() + (negative ? 1 : 0);
        if (negative && flags[F_ZERO])
        begin
            emit_char(CH_MINUS);
        end
        if (!flags[F_LEFT])
        begin
            while (w > actual)
            begin
                emit_char(flags[F_ZERO] ? CH_ZERO : CH_SPACE);
                w--;
            end
        end
        if (negative && !flags[F_ZERO])
        begin
            emit_char(CH_MINUS);
        end
        foreach (digits[i])
        begin
            emit_char(digits[i]);
        end
        emit_spaces((w < actual) ? 0 : w - actual);
    endtask

    task automatic format_step(input logic [7:0] c, input logic [31:0] arg);
        logic           taken;
        int             nw;
        expected_char_t item;
        taken = 1'b0;
        emit_buf.delete();
        if (c == CH_NUL)
        begin
            reset_spec();
            taken = 1'b1;
        end
        if (!taken && scan == SCAN_TEXT)
        begin
            if (c == CH_PCT)
            begin
                scan = SCAN_FLAGS;
            end
            else
            begin
                emit_char(c);
            end
            taken = 1'b1;
        end
        if (!taken && scan == SCAN_FLAGS)
        begin
            taken = 1'b1;
            if (c == CH_PCT)
            begin
                emit_char(CH_PCT);
                reset_spec();
            end
            else if (c == CH_MINUS)
            begin
                if (spec_fl[F_LEFT])
                begin
                    reset_spec();
                end
                else
                begin
                    spec_fl[F_LEFT] = 1'b1;
                end
            end
            else if (c == CH_ZERO)
            begin
                spec_fl[F_ZERO] = 1'b1;
                scan = SCAN_WIDTH;
            end
            else
            begin
                scan  = SCAN_WIDTH;
                taken = 1'b0;
            end
        end
        if (!taken && scan == SCAN_WIDTH)
        begin
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                nw = int'(field_w) * 10 + int'(c - CH_ZERO);
                field_w = (nw > MAX_WIDTH) ? WIDTH_W'(MAX_WIDTH) : WIDTH_W'(nw);
                taken = 1'b1;
            end
            else
            begin
                scan = SCAN_MODS;
            end
        end
        if (!taken && scan == SCAN_MODS)
        begin
            case (c)
                CH_MOD_F: spec_fl[F_FAR] = 1'b1;
                CH_MOD_N: ;
                CH_MOD_L: spec_fl[F_LONG] = 1'b1;
                CH_MOD_H: spec_fl[F_SHORT] = 1'b1;
                default:
                begin
                    render_conversion(c, arg, spec_fl, int'(field_w));
                    reset_spec();
                end
            endcase
        end
        foreach (emit_buf[i])
        begin
            item.ch  = emit_buf[i];
            item.fin = (i == emit_buf.size() - 1);
            expected_text.push_back(item);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int             errs;
        expected_char_t want;
        if (!rst_n)
        begin
            reset_spec();
            expected_text.delete();
            fail_count      <= 0;
            pending_results <= 0;
        end
        else
        begin
            errs = 0;
            if (out_valid && out_ready)
            begin
                if (expected_text.size() == 0)
                begin
                    $error("unexpected transaction: out_char 0x%02h, last %0b", out_char, last);
                    errs++;
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (out_char !== want.ch)
                    begin
                        $error("out_char mismatch: expected 0x%02h, actual 0x%02h",
                               want.ch, out_char);
                        errs++;
                    end
                    if (last !== want.fin)
                    begin
                        $error("last mismatch: expected %0b, actual %0b", want.fin, last);
                        errs++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                format_step(fmt_char, arg_value);
            end
            fail_count      <= fail_count + errs;
            pending_results <= expected_text.size();
        end
    end

endmodule

FILE: verif/tb_printf_format_engine_core.sv
`timescale 1ns / 1ps
// Top of the format engine testbench: clock, reset, format-character stimulus with
// random idling on both channels, and the verdict. Depends on pfe_pkg, the core and
// printf_format_engine_checker.
module tb_printf_format_engine_core;
    import pfe_pkg::*;

    localparam int MAX_WIDTH  = 63;
    localparam int LONG_HOLD  = 400;
    localparam int DRAIN      = 100;
    localparam int CYCLE_LIMIT = 600000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  fmt_char;
    logic [31:0] arg_value;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_char;
    logic        last;

    int fail_count;
    int pending_results;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int sent_items    = 0;
    int specs_sent    = 0;
    int cycle_count   = 0;

    printf_format_engine_core #(
        .MAX_WIDTH(MAX_WIDTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .fmt_char  (fmt_char),
        .arg_value (arg_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last      (last)
    );

    printf_format_engine_checker #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_format_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .fmt_char        (fmt_char),
        .arg_value       (arg_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_char        (out_char),
        .last            (last),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        int holds_served;
        int hold_left;
        holds_served = 0;
        hold_left    = 0;
        out_ready    = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_char(input logic [7:0] c, input logic [31:0] a);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        fmt_char  <= c;
        arg_value <= a;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_items++;
    endtask

    task automatic send_text(input string s, input logic [31:0] a);
        foreach (s[i])
        begin
            send_char(s[i], a);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_arg();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return {16'($urandom_range(65535)), 16'h8000};
            4:       return $urandom_range(999);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_conversion();
        case ($urandom_range(8))
            0:       return CH_CONV_D;
            1:       return CH_CONV_I;
            2:       return CH_CONV_U;
            3:       return CH_CONV_O;
            4:       return CH_CONV_LX;
            5:       return CH_CONV_UX;
            6:       return CH_CONV_P;
            7:       return CH_CONV_N;
            default: return CH_CONV_C;
        endcase
    endfunction

    task automatic send_random_sequence();
        int          kind;
        int          ndig;
        logic [7:0]  c;
        logic [31:0] a;
        kind = $urandom_range(99);
        a    = pick_arg();
        if (kind < 25)
        begin
            c = 8'($urandom_range(1, 255));
            if (c == CH_PCT)
            begin
                c = CH_UPPER_A;
            end
            send_char(c, a);
        end
        else if (kind < 85)
        begin
            send_char(CH_PCT, $urandom);
            case ($urandom_range(3))
                1: send_char(CH_MINUS, $urandom);
                2: send_char(CH_ZERO, $urandom);
                3:
                begin
                    send_char(CH_MINUS, $urandom);
                    send_char(CH_ZERO, $urandom);
                end
                default: ;
            endcase
            ndig = ($urandom_range(19) == 0) ? 3 : $urandom_range(2);
            repeat (ndig) send_char(CH_ZERO + 8'($urandom_range(9)), $urandom);
            if ($urandom_range(3) == 0) send_char(CH_MOD_F, $urandom);
            if ($urandom_range(3) == 0) send_char(CH_MOD_N, $urandom);
            if ($urandom_range(3) == 0) send_char(CH_MOD_H, $urandom);
            if ($urandom_range(3) == 0) send_char(CH_MOD_L, $urandom);
            send_char(pick_conversion(), a);
            specs_sent++;
        end
        else
        begin
            case ($urandom_range(3))
                0: send_char(8'($urandom_range(255)), $urandom);
                1:
                begin
                    send_char(CH_PCT, $urandom);
                    send_char(CH_MINUS, $urandom);
                    send_char(CH_MINUS, $urandom);
                end
                2:
                begin
                    send_char(CH_PCT, $urandom);
                    send_char(8'($urandom_range(255)), $urandom);
                end
                default: send_char(CH_NUL, $urandom);
            endcase
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        fmt_char  = 8'd0;
        arg_value = 32'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 23;
        recv_idle_pct = 49;
        send_text("A%%", 32'h0000_0000);
        send_text("%-3c", 32'hFFFF_FF00);
        send_text("%--", 32'h0000_0000);
        send_text("%s", 32'h0000_0041);
        send_text("%5", 32'h0000_0000);
        send_char(CH_NUL, 32'h0000_0000);
        send_text("%099hd", 32'h1234_8000);
        send_text("%6i", 32'hFFFF_FFFB);
        send_text("%hlX", 32'hDEAD_BEEF);
        send_text("%d", 32'h8000_0000);
        wait_drained();

        while (sent_items < 90) send_random_sequence();
        wait_drained();

        send_idle_pct = 49;
        recv_idle_pct = 23;
        hold_requests <= hold_requests + 1;
        send_text("%40u", $urandom);
        send_text("%-33x", $urandom);
        send_text("%063d", 32'h8000_0000);
        send_text("%20c", $urandom);
        while (sent_items < 150) send_random_sequence();
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (sent_items < 200) send_random_sequence();
        wait_drained();
        repeat (DRAIN) @(posedge clk);

        $display("Covered %0d format characters with %0d random conversion specs: flags,",
                 sent_items, specs_sent);
        $display("width saturation, h/l sizes, sign ordering, %%c, resets and a long stall.");
        if (fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
